>>> hw/rtl/ihc_pkg.sv
// Shared types and constants for the IPv4 header check and classify unit.
// No dependencies; imported by the top module and by ihc_core.
package ihc_pkg;

  typedef enum logic [2:0] {
    VerdictBad       = 3'd0,
    VerdictIcmp      = 3'd1,
    VerdictUdp       = 3'd2,
    VerdictOther     = 3'd3,
    VerdictMalformed = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  protocol_number;
    logic [15:0] payload_length;
    logic [5:0]  header_bytes;
    logic [15:0] computed_checksum;
  } out_beat_t;

  // Header byte offsets that the parser captures
  localparam logic [5:0] PosVerIhl  = 6'd0;
  localparam logic [5:0] PosTotHi   = 6'd2;
  localparam logic [5:0] PosTotLo   = 6'd3;
  localparam logic [5:0] PosProto   = 6'd9;
  localparam logic [5:0] PosCsumHi  = 6'd10;
  localparam logic [5:0] PosCsumLo  = 6'd11;

  localparam logic [3:0] MinIhl     = 4'd5;
  localparam logic [5:0] MinHdrBytes = 6'd20;
  localparam logic [7:0] ProtoIcmp  = 8'd1;
  localparam logic [7:0] ProtoUdp   = 8'd17;

  typedef struct packed {
    logic valid;
    logic stall;
  } hs_t;

endpackage

>>> hw/rtl/ipv4_header_check_classify_unit.sv
// IPv4 header check and classify: takes one packet byte per beat (header byte 0 first) and
// gives one result beat per packet when the header ends, or a malformed verdict for a short
// or truncated header. A byte beat is accepted every cycle while the output keeps flowing.
// The beat holding the last header byte passes through the input register, then a combinational
// parse and 16-bit end-around-carry add feed the result register, which presents the result beat.
// Both channels are valid/stall, and a held result stalls input only when the result
// register is full and stalled.
module ipv4_header_check_classify_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ihc_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ihc_pkg::out_beat_t out_beat_o
);
  import ihc_pkg::*;

  localparam int unsigned InW  = $bits(in_beat_t);
  localparam int unsigned OutW = $bits(out_beat_t);

  logic [InW-1:0]  in_data_q;
  logic [OutW-1:0] out_data_q;
  in_beat_t        beat;
  out_beat_t       res;
  logic            res_valid;
  logic            beat_valid;
  logic            beat_stall;
  hs_t             beat_hs;

  ihc_pipe_reg #(.Width(InW)) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_beat_i),
    .valid_o (beat_valid),
    .stall_i (beat_stall),
    .data_o  (in_data_q)
  );

  assign beat    = in_data_q;
  assign beat_hs = {beat_valid, beat_stall};

  ihc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_hs_i   (beat_hs),
    .beat_i      (beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihc_pipe_reg #(.Width(OutW)) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .stall_o (beat_stall),
    .data_i  (res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_q)
  );

  assign out_beat_o = out_data_q;

endmodule

>>> hw/rtl/ihc_pipe_reg.sv
// Single-entry valid/stall pipeline register with full throughput.
// Depends on nothing; used for the input and result stages of the unit.
module ihc_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // only back-pressure upstream when holding a beat that cannot leave
  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/ihc_core.sv
// Header parser: byte position, checksum accumulator, field capture and verdict.
// Depends on ihc_pkg.
module ihc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ihc_pkg::hs_t      beat_hs_i,
  input  ihc_pkg::in_beat_t beat_i,
  output logic              res_valid_o,
  output ihc_pkg::out_beat_t res_o
);
  import ihc_pkg::*;

  logic        take;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hi_q, hi_d;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] tot_q, tot_d;
  logic [15:0] csum_q, csum_d;
  logic [7:0]  proto_q, proto_d;
  logic        done_q, done_d;

  logic [15:0] word;
  logic [16:0] sum_wide;
  logic [15:0] sum_add;
  logic [5:0]  hbytes;
  logic        end_hdr;
  logic        short_hdr;
  logic [15:0] comp;
  logic [15:0] pay;
  logic [7:0]  b;
  logic        last;
  verdict_e    cls;

  assign take = beat_hs_i.valid & ~beat_hs_i.stall;
  assign b    = beat_i.data_byte;
  assign last = beat_i.last_byte;

  always_comb begin
    nib_d   = (pos_q == PosVerIhl) ? b[3:0] : nib_q;
    tot_d   = tot_q;
    proto_d = (pos_q == PosProto) ? b : proto_q;
    csum_d  = csum_q;
    if (pos_q == PosTotHi) tot_d = {b, tot_q[7:0]};
    if (pos_q == PosTotLo) tot_d = {tot_q[15:8], b};
    if (pos_q == PosCsumHi) csum_d = {b, csum_q[7:0]};
    if (pos_q == PosCsumLo) csum_d = {csum_q[15:8], b};
    hi_d = pos_q[0] ? hi_q : b;
  end

  // checksum word counts as zero; end-around carry folded straight back
  assign word     = (pos_q == PosCsumLo) ? 16'd0 : {hi_q, b};
  assign sum_wide = {1'b0, sum_q} + {1'b0, word};
  assign sum_add  = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
  assign sum_d    = pos_q[0] ? sum_add : sum_q;

  assign hbytes    = {nib_d, 2'b00};
  assign end_hdr   = ({1'b0, pos_q} + 7'd1) == {1'b0, hbytes};
  assign short_hdr = nib_d < MinIhl;
  assign comp      = ~sum_d;
  assign pay       = (tot_d > {10'd0, hbytes}) ? (tot_d - {10'd0, hbytes}) : 16'd0;

  always_comb begin
    if (comp != csum_d) begin
      cls = VerdictBad;
    end else if (proto_d == ProtoIcmp) begin
      cls = VerdictIcmp;
    end else if (proto_d == ProtoUdp) begin
      cls = VerdictUdp;
    end else begin
      cls = VerdictOther;
    end
  end

  always_comb begin
    res_valid_o             = 1'b0;
    res_o.verdict           = VerdictMalformed;
    res_o.protocol_number   = 8'd0;
    res_o.payload_length    = 16'd0;
    res_o.header_bytes      = hbytes;
    res_o.computed_checksum = 16'd0;
    if (beat_hs_i.valid && !done_q) begin
      if (short_hdr) begin
        res_valid_o = 1'b1;
      end else if (end_hdr) begin
        res_valid_o             = 1'b1;
        res_o.verdict           = cls;
        res_o.protocol_number   = proto_d;
        res_o.payload_length    = pay;
        res_o.computed_checksum = comp;
      end else if (last) begin
        res_valid_o = 1'b1;  // packet ended inside the header
      end
    end
  end

  assign pos_d  = pos_q + 6'd1;
  assign done_d = short_hdr | end_hdr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      hi_q    <= '0;
      nib_q   <= '0;
      tot_q   <= '0;
      csum_q  <= '0;
      proto_q <= '0;
      done_q  <= 1'b0;
    end else if (take) begin
      if (last) begin
        pos_q   <= '0;
        sum_q   <= '0;
        hi_q    <= '0;
        nib_q   <= '0;
        tot_q   <= '0;
        csum_q  <= '0;
        proto_q <= '0;
        done_q  <= 1'b0;
      end else if (!done_q) begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        hi_q    <= hi_d;
        nib_q   <= nib_d;
        tot_q   <= tot_d;
        csum_q  <= csum_d;
        proto_q <= proto_d;
        done_q  <= done_d;
      end
    end
  end

  a_no_result_after_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_hs_i.valid && done_q) |-> !res_valid_o)
    else $error("result raised after header already finished");

  a_malformed_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.verdict == VerdictMalformed) |->
      (res_o.computed_checksum == 16'd0 && res_o.payload_length == 16'd0 &&
       res_o.protocol_number == 8'd0))
    else $error("malformed result carries non-zero fields");

  a_good_header_min_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.verdict != VerdictMalformed) |-> (res_o.header_bytes >= MinHdrBytes))
    else $error("classified header shorter than minimum");

  a_last_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last) |=> (pos_q == 6'd0 && !done_q && sum_q == 16'd0))
    else $error("parser not idle after last beat");

endmodule
